[hw/rtl/tcqg_pkg.sv]
// Shared types, constants and the control store for the tile chunk quad generator.
// No dependencies; every other RTL file imports this package.
`default_nettype none

package tcqg_pkg;

	// Configuration limits
	localparam int MAX_MAP_DIM   = 1024;
	localparam int MAX_CHUNK_DIM = 64;
	localparam int MAX_TILE_PIX  = 256;
	localparam int MAX_ATLAS_ROW = 256;

	// Register widths
	localparam int COL_W   = 11;
	localparam int CS_W    = 7;
	localparam int TS_W    = 9;
	localparam int TPR_W   = 9;
	localparam int INSET_W = 8;
	localparam int CFG_W   = 11;
	localparam int IDX_W   = 3;

	// Register indexes
	localparam logic [IDX_W-1:0] REG_MAP_COLS   = 3'd0;
	localparam logic [IDX_W-1:0] REG_MAP_ROWS   = 3'd1;
	localparam logic [IDX_W-1:0] REG_CHUNK_SIZE = 3'd2;
	localparam logic [IDX_W-1:0] REG_TILE_SIZE  = 3'd3;
	localparam logic [IDX_W-1:0] REG_ATLAS_ROW  = 3'd4;
	localparam logic [IDX_W-1:0] REG_TEX_INSET  = 3'd5;

	// Word fields
	localparam int TILE_W   = 13;
	localparam int DIVD_W   = 12;
	localparam int CHUNK_W  = 10;
	localparam int TILEPOS_W = 6;
	localparam int SLOT_W   = 3;
	localparam int POS_W    = 18;
	localparam int TEX_W    = 24;

	localparam logic [SLOT_W-1:0] LAST_SLOT = 3'd5;

	// Sequencer
	localparam int PC_W = 3;

	localparam logic [PC_W-1:0] ST_FETCH = 3'd0;
	localparam logic [PC_W-1:0] ST_MUL_X = 3'd1;
	localparam logic [PC_W-1:0] ST_MUL_Y = 3'd2;
	localparam logic [PC_W-1:0] ST_DIV   = 3'd3;
	localparam logic [PC_W-1:0] ST_MUL_U = 3'd4;
	localparam logic [PC_W-1:0] ST_MUL_V = 3'd5;
	localparam logic [PC_W-1:0] ST_EMIT  = 3'd6;
	localparam logic [PC_W-1:0] ST_ADV   = 3'd7;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_X,
		MUL_Y,
		MUL_U,
		MUL_V
	} mul_op_t;

	typedef enum logic [1:0] {
		JMP_NEXT,
		JMP_ALWAYS,
		JMP_DIV_BUSY,
		JMP_MORE_VERT
	} jmp_t;

	typedef struct packed {
		logic            wait_in;
		logic            div_step;
		mul_op_t         mul_op;
		logic            emit;
		logic            advance;
		jmp_t            jmp;
		logic [PC_W-1:0] target;
	} ctrl_word_t;

	typedef struct packed {
		logic out_free;
		logic div_last;
		logic slot_last;
	} status_t;

	typedef struct packed {
		logic [COL_W-1:0]   cols;
		logic [COL_W-1:0]   rows;
		logic [CS_W-1:0]    cs;
		logic [TS_W-1:0]    ts;
		logic [TPR_W-1:0]   tpr;
		logic [INSET_W-1:0] inset;
	} cfg_t;

	// Control store: one word per step
	function automatic ctrl_word_t ucode(input logic [PC_W-1:0] pc);
		ctrl_word_t w;
		w         = '0;
		w.mul_op  = MUL_NONE;
		w.jmp     = JMP_NEXT;
		case (pc)
			ST_FETCH: begin
				w.wait_in = 1'b1;
			end
			ST_MUL_X: begin
				w.mul_op = MUL_X;
			end
			ST_MUL_Y: begin
				w.mul_op = MUL_Y;
			end
			ST_DIV: begin
				w.div_step = 1'b1;
				w.jmp      = JMP_DIV_BUSY;
				w.target   = ST_DIV;
			end
			ST_MUL_U: begin
				w.mul_op = MUL_U;
			end
			ST_MUL_V: begin
				w.mul_op = MUL_V;
			end
			ST_EMIT: begin
				w.emit   = 1'b1;
				w.jmp    = JMP_MORE_VERT;
				w.target = ST_EMIT;
			end
			ST_ADV: begin
				w.advance = 1'b1;
				w.jmp     = JMP_ALWAYS;
				w.target  = ST_FETCH;
			end
			default: begin
				w.jmp    = JMP_ALWAYS;
				w.target = ST_FETCH;
			end
		endcase
		return w;
	endfunction

	// Corners per slot are 0,1,2,0,2,3; corners 1,2 lie right, 2,3 lie at the bottom
	function automatic logic slot_right(input logic [SLOT_W-1:0] s);
		case (s)
			3'd1, 3'd2, 3'd4: return 1'b1;
			default:          return 1'b0;
		endcase
	endfunction

	function automatic logic slot_bottom(input logic [SLOT_W-1:0] s);
		case (s)
			3'd2, 3'd4, 3'd5: return 1'b1;
			default:          return 1'b0;
		endcase
	endfunction

endpackage

`default_nettype wire

[hw/rtl/tcqg_divider.sv]
// Restoring divider, one quotient bit per step: tile number over atlas row width.
// Depends on tcqg_pkg.
`default_nettype none

module tcqg_divider
	import tcqg_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire logic              step,
	input  wire logic [DIVD_W-1:0] dividend,
	input  wire logic [TPR_W-1:0]  divisor,
	output logic      [DIVD_W-1:0] quot,
	output logic      [TPR_W-1:0]  rem,
	output logic                   last
);

	localparam int CNT_W = $clog2(DIVD_W);

	logic [CNT_W-1:0]  cnt_q;
	logic [DIVD_W-1:0] dq_q;
	logic [TPR_W-1:0]  rem_q;
	logic [TPR_W:0]    trial;
	logic              ge;

	assign trial = {rem_q, dq_q[DIVD_W-1]};
	assign ge    = trial >= {1'b0, divisor};
	assign last  = cnt_q == CNT_W'(DIVD_W - 1);
	assign quot  = dq_q;
	assign rem   = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= '0;
		end else if (step) begin
			cnt_q <= cnt_q + CNT_W'(1);
		end
	end

	// dividend shifts out at the top while quotient bits shift in below
	always_ff @(posedge clk) begin
		if (start) begin
			dq_q  <= dividend;
			rem_q <= '0;
		end else if (step) begin
			dq_q  <= {dq_q[DIVD_W-2:0], ge};
			rem_q <= ge ? TPR_W'(trial - {1'b0, divisor}) : trial[TPR_W-1:0];
		end
	end

endmodule

`default_nettype wire

[hw/rtl/tcqg_sequencer.sv]
// Step counter and jump logic over the control store held in tcqg_pkg.
// Depends on tcqg_pkg.
`default_nettype none

module tcqg_sequencer
	import tcqg_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	input  wire status_t    st,
	output ctrl_word_t      ctrl
);

	logic [PC_W-1:0] pc_q;
	logic [PC_W-1:0] pc_d;
	logic            hold;

	assign ctrl = ucode(pc_q);

	always_comb begin
		hold = (ctrl.wait_in && !in_valid) || (ctrl.emit && !st.out_free);
		pc_d = pc_q;
		if (!hold) begin
			case (ctrl.jmp)
				JMP_NEXT:      pc_d = pc_q + PC_W'(1);
				JMP_ALWAYS:    pc_d = ctrl.target;
				JMP_DIV_BUSY:  pc_d = st.div_last ? pc_q + PC_W'(1) : ctrl.target;
				JMP_MORE_VERT: pc_d = st.slot_last ? pc_q + PC_W'(1) : ctrl.target;
				default:       pc_d = ST_FETCH;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= ST_FETCH;
		end else begin
			pc_q <= pc_d;
		end
	end

	a_fetch_to_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.wait_in && in_valid) |=> (pc_q == ST_MUL_X))
		else $error("accepted word did not move on to the first multiply");

	a_div_loops: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == ST_DIV && !st.div_last) |=> (pc_q == ST_DIV))
		else $error("divide loop left early");

	a_emit_waits: assert property (@(posedge clk) disable iff (!arst_n)
		(pc_q == ST_EMIT && !st.out_free) |=> (pc_q == ST_EMIT))
		else $error("emit step moved on while output register was full");

endmodule

`default_nettype wire

[hw/rtl/tcqg_datapath.sv]
// Scan counters, shared multiplier, vertex arithmetic and output register.
// Depends on tcqg_pkg and tcqg_divider.
`default_nettype none

module tcqg_datapath
	import tcqg_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire cfg_t                 cfg,
	input  wire logic                 restart,
	input  wire ctrl_word_t           ctrl,
	input  wire logic                 in_valid,
	input  wire logic [TILE_W-1:0]    tile_index,
	input  wire logic                 out_stall,
	output status_t                   st,
	output logic                      out_valid,
	output logic      [CHUNK_W-1:0]   chunk_col,
	output logic      [CHUNK_W-1:0]   chunk_row,
	output logic      [SLOT_W-1:0]    vertex_slot,
	output logic      [POS_W-1:0]     pos_x,
	output logic      [POS_W-1:0]     pos_y,
	output logic      [TEX_W-1:0]     tex_u,
	output logic      [TEX_W-1:0]     tex_v,
	output logic                      chunk_has_tile,
	output logic                      last_of_tile,
	output logic                      last_of_chunk,
	output logic                      last_of_map
);

	localparam int PROD_W = DIVD_W + TS_W;

	// scan state
	logic [CHUNK_W-1:0]   chunk_col_q, chunk_row_q;
	logic [CHUNK_W-1:0]   org_x_q, org_y_q;
	logic [TILEPOS_W-1:0] tx_q, ty_q;
	logic                 nonempty_q;
	logic [SLOT_W-1:0]    slot_q;
	logic                 out_valid_q;

	// per-word working registers
	logic               empty_q;
	logic [CHUNK_W-1:0] mx_q, my_q;
	logic               x_last_q, end_chunk_q, end_map_q, last_ccol_q;
	logic [POS_W-1:0]   xb_q, yb_q;
	logic [15:0]        ub_q;
	logic [19:0]        vb_q;

	// output word
	logic [CHUNK_W-1:0] ocol_q, orow_q;
	logic [SLOT_W-1:0]  oslot_q;
	logic [POS_W-1:0]   opx_q, opy_q;
	logic [TEX_W-1:0]   ou_q, ov_q;
	logic               ohas_q, olt_q, olc_q, olm_q;

	logic in_fire, emit_fire, out_free;
	logic div_last;
	logic [DIVD_W-1:0] quot;
	logic [TPR_W-1:0]  rem;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_fire   = ctrl.wait_in && in_valid;
	assign emit_fire = ctrl.emit && out_free;

	assign st.out_free  = out_free;
	assign st.div_last  = div_last;
	assign st.slot_last = slot_q == LAST_SLOT;

	tcqg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (in_fire),
		.step     (ctrl.div_step),
		.dividend (tile_index[DIVD_W-1:0]),
		.divisor  (cfg.tpr),
		.quot     (quot),
		.rem      (rem),
		.last     (div_last)
	);

	// tile position and end-of-chunk / end-of-map flags, taken at fetch
	logic [CS_W-1:0]    tx_inc, ty_inc;
	logic [COL_W-1:0]   mx_inc, my_inc;
	logic               x_last_c, y_last_c, last_ccol_c, last_crow_c;

	always_comb begin
		tx_inc      = {1'b0, tx_q} + CS_W'(1);
		ty_inc      = {1'b0, ty_q} + CS_W'(1);
		mx_inc      = {1'b0, org_x_q} + COL_W'(tx_q) + COL_W'(1);
		my_inc      = {1'b0, org_y_q} + COL_W'(ty_q) + COL_W'(1);
		x_last_c    = (tx_inc == cfg.cs) || (mx_inc == cfg.cols);
		y_last_c    = (ty_inc == cfg.cs) || (my_inc == cfg.rows);
		last_ccol_c = ({1'b0, org_x_q} + COL_W'(cfg.cs)) >= cfg.cols;
		last_crow_c = ({1'b0, org_y_q} + COL_W'(cfg.cs)) >= cfg.rows;
	end

	// shared multiplier, one product per step
	logic [DIVD_W-1:0] mul_a;
	logic [PROD_W-1:0] mul_p;

	always_comb begin
		case (ctrl.mul_op)
			MUL_X:   mul_a = DIVD_W'(mx_q);
			MUL_Y:   mul_a = DIVD_W'(my_q);
			MUL_U:   mul_a = DIVD_W'(rem);
			MUL_V:   mul_a = quot;
			default: mul_a = '0;
		endcase
	end

	assign mul_p = PROD_W'(mul_a) * PROD_W'(cfg.ts);

	// vertex arithmetic for the current slot
	logic              right, bottom;
	logic [POS_W:0]    px, py;
	logic [16:0]       ub;
	logic [24:0]       u;
	logic [20:0]       vb;
	logic [29:0]       v29, v;
	logic [POS_W-1:0]  px_sat, py_sat;
	logic [TEX_W-1:0]  u_sat, v_sat;

	always_comb begin
		right  = slot_right(slot_q);
		bottom = slot_bottom(slot_q);
		px     = {1'b0, xb_q} + (right  ? (POS_W+1)'(cfg.ts) : '0);
		py     = {1'b0, yb_q} + (bottom ? (POS_W+1)'(cfg.ts) : '0);
		ub     = {1'b0, ub_q} + (right  ? 17'(cfg.ts) : 17'd0);
		vb     = {1'b0, vb_q} + (bottom ? 21'(cfg.ts) : 21'd0);
		// right and bottom corners pull the texel inwards, the others push
		u      = right  ? {ub, 8'd0} - 25'(cfg.inset) : {ub, 8'd0} + 25'(cfg.inset);
		v29    = {1'b0, vb, 8'd0};
		v      = bottom ? v29 - 30'(cfg.inset) : v29 + 30'(cfg.inset);
		px_sat = px[POS_W] ? '1 : px[POS_W-1:0];
		py_sat = py[POS_W] ? '1 : py[POS_W-1:0];
		u_sat  = u[24] ? '1 : u[TEX_W-1:0];
		v_sat  = (|v[29:24]) ? '1 : v[TEX_W-1:0];
		if (empty_q) begin
			px_sat = '0;
			py_sat = '0;
			u_sat  = '0;
			v_sat  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chunk_col_q <= '0;
			chunk_row_q <= '0;
			org_x_q     <= '0;
			org_y_q     <= '0;
			tx_q        <= '0;
			ty_q        <= '0;
			nonempty_q  <= 1'b0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (restart) begin
				chunk_col_q <= '0;
				chunk_row_q <= '0;
				org_x_q     <= '0;
				org_y_q     <= '0;
				tx_q        <= '0;
				ty_q        <= '0;
				nonempty_q  <= 1'b0;
			end else if (in_fire) begin
				if (!tile_index[TILE_W-1]) begin
					nonempty_q <= 1'b1;
				end
			end else if (ctrl.advance) begin
				if (!end_chunk_q) begin
					if (!x_last_q) begin
						tx_q <= tx_q + TILEPOS_W'(1);
					end else begin
						tx_q <= '0;
						ty_q <= ty_q + TILEPOS_W'(1);
					end
				end else begin
					tx_q       <= '0;
					ty_q       <= '0;
					nonempty_q <= 1'b0;
					if (end_map_q) begin
						chunk_col_q <= '0;
						chunk_row_q <= '0;
						org_x_q     <= '0;
						org_y_q     <= '0;
					end else if (!last_ccol_q) begin
						chunk_col_q <= chunk_col_q + CHUNK_W'(1);
						org_x_q     <= org_x_q + CHUNK_W'(cfg.cs);
					end else begin
						chunk_col_q <= '0;
						org_x_q     <= '0;
						chunk_row_q <= chunk_row_q + CHUNK_W'(1);
						org_y_q     <= org_y_q + CHUNK_W'(cfg.cs);
					end
				end
			end

			if (in_fire) begin
				slot_q <= '0;
			end else if (emit_fire) begin
				slot_q <= st.slot_last ? '0 : slot_q + SLOT_W'(1);
			end

			if (emit_fire) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			empty_q     <= tile_index[TILE_W-1];
			mx_q        <= CHUNK_W'(mx_inc - COL_W'(1));
			my_q        <= CHUNK_W'(my_inc - COL_W'(1));
			x_last_q    <= x_last_c;
			end_chunk_q <= x_last_c && y_last_c;
			end_map_q   <= x_last_c && y_last_c && last_ccol_c && last_crow_c;
			last_ccol_q <= last_ccol_c;
		end
		case (ctrl.mul_op)
			MUL_X:   xb_q <= mul_p[POS_W-1:0];
			MUL_Y:   yb_q <= mul_p[POS_W-1:0];
			MUL_U:   ub_q <= mul_p[15:0];
			MUL_V:   vb_q <= mul_p[19:0];
			default: ;
		endcase
		if (emit_fire) begin
			ocol_q  <= chunk_col_q;
			orow_q  <= chunk_row_q;
			oslot_q <= slot_q;
			opx_q   <= px_sat;
			opy_q   <= py_sat;
			ou_q    <= u_sat;
			ov_q    <= v_sat;
			ohas_q  <= nonempty_q;
			olt_q   <= st.slot_last;
			olc_q   <= st.slot_last && end_chunk_q;
			olm_q   <= st.slot_last && end_map_q;
		end
	end

	assign out_valid      = out_valid_q;
	assign chunk_col      = ocol_q;
	assign chunk_row      = orow_q;
	assign vertex_slot    = oslot_q;
	assign pos_x          = opx_q;
	assign pos_y          = opy_q;
	assign tex_u          = ou_q;
	assign tex_v          = ov_q;
	assign chunk_has_tile = ohas_q;
	assign last_of_tile   = olt_q;
	assign last_of_chunk  = olc_q;
	assign last_of_map    = olm_q;

	a_map_end_in_chunk_end: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && olm_q) |-> (olc_q && olt_q))
		else $error("end of map flagged outside end of chunk");

	a_tile_in_map: assert property (@(posedge clk) disable iff (!arst_n)
		(({1'b0, tx_q} < cfg.cs) && (({1'b0, org_x_q} + COL_W'(tx_q)) < cfg.cols)
		 && (({1'b0, org_y_q} + COL_W'(ty_q)) < cfg.rows)))
		else $error("scan position outside the map");

	a_slot_wrapped: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.advance |-> (slot_q == '0))
		else $error("scan advanced before all six vertices left");

endmodule

`default_nettype wire

[hw/rtl/tile_chunk_quad_generator_unit.sv]
// Top level of the tile chunk quad generator: configuration registers and block wiring.
// Depends on tcqg_pkg, tcqg_sequencer, tcqg_datapath (and tcqg_divider below it).
//
//  channel   direction  handshake                 payload
//  input     in         in_valid / in_stall       tile_index
//  output    out        out_valid / out_stall     chunk_col .. last_of_map (six words per tile)
//  config    in         cfg_write                 cfg_index, cfg_data
//
// With the output never stalled, a tile runs through fetch, two position multiplies,
// 12 divide steps (one quotient bit a cycle), two texture multiplies, six vertex words, advance.
// The next tile is taken in the cycle after the advance step; the sixth word may still sit
// in the output register then. A stall on out holds the emit step until the register frees.
// Reset clears the scan to chunk (0,0) and loads the default register values; no clearing pass.
`default_nettype none

module tile_chunk_quad_generator_unit
	import tcqg_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_write,
	input  wire logic [IDX_W-1:0]     cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [TILE_W-1:0]    tile_index,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic      [CHUNK_W-1:0]   chunk_col,
	output logic      [CHUNK_W-1:0]   chunk_row,
	output logic      [SLOT_W-1:0]    vertex_slot,
	output logic      [POS_W-1:0]     pos_x,
	output logic      [POS_W-1:0]     pos_y,
	output logic      [TEX_W-1:0]     tex_u,
	output logic      [TEX_W-1:0]     tex_v,
	output logic                      chunk_has_tile,
	output logic                      last_of_tile,
	output logic                      last_of_chunk,
	output logic                      last_of_map
);

	cfg_t       cfg_q;
	logic       restart;
	ctrl_word_t ctrl;
	status_t    st;

	// all registers but the inset hold clamped values, so the datapath never sees zero or oversize
	function automatic logic [COL_W-1:0] clamp_dim(input logic [COL_W-1:0] x);
		if (x == '0)                     return COL_W'(1);
		else if (x > COL_W'(MAX_MAP_DIM)) return COL_W'(MAX_MAP_DIM);
		else                             return x;
	endfunction

	function automatic logic [CS_W-1:0] clamp_cs(input logic [CS_W-1:0] x);
		if (x == '0)                       return CS_W'(1);
		else if (x > CS_W'(MAX_CHUNK_DIM)) return CS_W'(MAX_CHUNK_DIM);
		else                               return x;
	endfunction

	function automatic logic [TS_W-1:0] clamp_256(input logic [TS_W-1:0] x);
		if (x == '0)                      return TS_W'(1);
		else if (x > TS_W'(MAX_TILE_PIX)) return TS_W'(MAX_TILE_PIX);
		else                              return x;
	endfunction

	always_comb begin
		case (cfg_index)
			REG_MAP_COLS, REG_MAP_ROWS, REG_CHUNK_SIZE,
			REG_TILE_SIZE, REG_ATLAS_ROW, REG_TEX_INSET: restart = cfg_write;
			default:                                      restart = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cols  <= COL_W'(64);
			cfg_q.rows  <= COL_W'(64);
			cfg_q.cs    <= CS_W'(16);
			cfg_q.ts    <= TS_W'(16);
			cfg_q.tpr   <= TPR_W'(16);
			cfg_q.inset <= '0;
		end else if (cfg_write) begin
			case (cfg_index)
				REG_MAP_COLS:   cfg_q.cols  <= clamp_dim(cfg_data);
				REG_MAP_ROWS:   cfg_q.rows  <= clamp_dim(cfg_data);
				REG_CHUNK_SIZE: cfg_q.cs    <= clamp_cs(cfg_data[CS_W-1:0]);
				REG_TILE_SIZE:  cfg_q.ts    <= clamp_256(cfg_data[TS_W-1:0]);
				REG_ATLAS_ROW:  cfg_q.tpr   <= clamp_256(cfg_data[TPR_W-1:0]);
				REG_TEX_INSET:  cfg_q.inset <= cfg_data[INSET_W-1:0];
				default: ;
			endcase
		end
	end

	assign in_stall = !ctrl.wait_in;

	tcqg_sequencer u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.ctrl     (ctrl)
	);

	tcqg_datapath u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.restart        (restart),
		.ctrl           (ctrl),
		.in_valid       (in_valid),
		.tile_index     (tile_index),
		.out_stall      (out_stall),
		.st             (st),
		.out_valid      (out_valid),
		.chunk_col      (chunk_col),
		.chunk_row      (chunk_row),
		.vertex_slot    (vertex_slot),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.tex_u          (tex_u),
		.tex_v          (tex_v),
		.chunk_has_tile (chunk_has_tile),
		.last_of_tile   (last_of_tile),
		.last_of_chunk  (last_of_chunk),
		.last_of_map    (last_of_map)
	);

endmodule

`default_nettype wire

[tb/tb.sv]
// Self-checking bench for tile_chunk_quad_generator_unit: a directed table, then random phases
// over small clipped maps; every vertex word is checked against an in-bench model of the scan.
// Depends on tcqg_pkg and the RTL only.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tcqg_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_CYCLES  = 40;
	localparam int PHASE_TILES   = 36;
	localparam int SCRIPT_LEN    = 30;

	localparam logic [IDX_W-1:0]  REG_SPARE_6   = 3'd6;
	localparam logic [IDX_W-1:0]  REG_SPARE_7   = 3'd7;
	localparam logic [TILE_W-1:0] EMPTY_TILE    = 13'h1FFF;	// -1
	localparam logic [TILE_W-1:0] MOST_NEG_TILE = 13'h1000;	// -4096, empty as well
	localparam logic [TILE_W-1:0] TOP_TILE      = 13'h0FFF;	// 4095

	localparam longint unsigned POS_CEIL = 64'd262143;
	localparam longint unsigned TEX_CEIL = 64'd16777215;

	typedef struct packed {
		logic [CHUNK_W-1:0] ccol;
		logic [CHUNK_W-1:0] crow;
		logic [SLOT_W-1:0]  slot;
		logic [POS_W-1:0]   px;
		logic [POS_W-1:0]   py;
		logic [TEX_W-1:0]   u;
		logic [TEX_W-1:0]   v;
		logic               has_tile;
		logic               end_tile;
		logic               end_chunk;
		logic               end_map;
	} vertex_t;

	typedef enum logic {ROW_TILE, ROW_REG} row_kind_t;

	typedef struct {
		row_kind_t          kind;
		logic [IDX_W-1:0]   idx;
		logic [CFG_W-1:0]   data;
		logic [TILE_W-1:0]  tile;
		bit                 typed;	// slot 0 position and texture given below
		logic [POS_W-1:0]   x0;
		logic [POS_W-1:0]   y0;
		logic [TEX_W-1:0]   u0;
		logic [TEX_W-1:0]   v0;
	} script_row_t;

	script_row_t script [SCRIPT_LEN] = '{
		// reset settings: 64x64 map, chunk 16, tile 16 px, 16 per atlas row, no inset
		'{ROW_TILE, REG_MAP_COLS, 0, 0, 1, 0, 0, 0, 0},
		'{ROW_TILE, REG_MAP_COLS, 0, EMPTY_TILE, 1, 0, 0, 0, 0},
		'{ROW_TILE, REG_MAP_COLS, 0, TOP_TILE, 1, 32, 0, 61440, 1044480},
		'{ROW_TILE, REG_MAP_COLS, 0, MOST_NEG_TILE, 1, 0, 0, 0, 0},
		'{ROW_TILE, REG_MAP_COLS, 0, 1234, 0, 0, 0, 0, 0},
		// widest tiles and atlas, full inset
		'{ROW_REG, REG_TILE_SIZE, 256, 0, 0, 0, 0, 0, 0},
		'{ROW_REG, REG_ATLAS_ROW, 256, 0, 0, 0, 0, 0, 0},
		'{ROW_REG, REG_TEX_INSET, 255, 0, 0, 0, 0, 0, 0},
		'{ROW_TILE, REG_MAP_COLS, 0, 255, 1, 0, 0, 16711935, 255},
		'{ROW_TILE, REG_MAP_COLS, 0, TOP_TILE, 0, 0, 0, 0, 0},
		// zero registers act as one: a 1x1 map, every tile ends the map
		'{ROW_REG, REG_TILE_SIZE, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_REG, REG_ATLAS_ROW, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_REG, REG_CHUNK_SIZE, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_REG, REG_MAP_COLS, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_REG, REG_MAP_ROWS, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_TILE, REG_MAP_COLS, 0, 5, 1, 0, 0, 255, 1535},
		'{ROW_TILE, REG_MAP_COLS, 0, EMPTY_TILE, 0, 0, 0, 0, 0},
		'{ROW_TILE, REG_MAP_COLS, 0, TOP_TILE, 0, 0, 0, 0, 0},
		// over-range registers clamp; texture saturates with no inset
		'{ROW_REG, REG_MAP_COLS, 2047, 0, 0, 0, 0, 0, 0},
		'{ROW_REG, REG_MAP_ROWS, 1025, 0, 0, 0, 0, 0, 0},
		'{ROW_REG, REG_CHUNK_SIZE, 127, 0, 0, 0, 0, 0, 0},
		'{ROW_REG, REG_TILE_SIZE, 511, 0, 0, 0, 0, 0, 0},
		'{ROW_REG, REG_ATLAS_ROW, 511, 0, 0, 0, 0, 0, 0},
		'{ROW_REG, REG_TEX_INSET, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_TILE, REG_MAP_COLS, 0, TOP_TILE, 0, 0, 0, 0, 0},
		'{ROW_TILE, REG_MAP_COLS, 0, EMPTY_TILE, 0, 0, 0, 0, 0},
		'{ROW_TILE, REG_MAP_COLS, 0, 0, 0, 0, 0, 0, 0},
		// unused indexes must leave the scan where it was
		'{ROW_REG, REG_SPARE_6, 2047, 0, 0, 0, 0, 0, 0},
		'{ROW_REG, REG_SPARE_7, 0, 0, 0, 0, 0, 0, 0},
		'{ROW_TILE, REG_MAP_COLS, 0, 1, 0, 0, 0, 0, 0}
	};

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                cfg_write  = 1'b0;
	logic [IDX_W-1:0]    cfg_index  = '0;
	logic [CFG_W-1:0]    cfg_data   = '0;
	logic                in_valid   = 1'b0;
	logic [TILE_W-1:0]   tile_index = '0;
	logic                out_stall  = 1'b0;
	logic                in_stall;
	logic                out_valid;
	logic [CHUNK_W-1:0]  chunk_col;
	logic [CHUNK_W-1:0]  chunk_row;
	logic [SLOT_W-1:0]   vertex_slot;
	logic [POS_W-1:0]    pos_x;
	logic [POS_W-1:0]    pos_y;
	logic [TEX_W-1:0]    tex_u;
	logic [TEX_W-1:0]    tex_v;
	logic                chunk_has_tile;
	logic                last_of_tile;
	logic                last_of_chunk;
	logic                last_of_map;

	bit gaps_on   = 1'b1;
	bit stalls_on = 1'b1;
	bit hold_req  = 1'b0;
	int hold_left  = 0;
	int stall_left = 0;
	int cycles     = 0;
	int mismatches = 0;
	int vertices_checked = 0;
	int tiles_sent = 0;
	int reg_writes = 0;

	// model of the scan and the registers
	cfg_t        shadow;
	int unsigned scan_col, scan_row, tile_x, tile_y;
	bit          chunk_seen;
	vertex_t     pending_vertices[$];

	tile_chunk_quad_generator_unit u_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_write      (cfg_write),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.tile_index     (tile_index),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.chunk_col      (chunk_col),
		.chunk_row      (chunk_row),
		.vertex_slot    (vertex_slot),
		.pos_x          (pos_x),
		.pos_y          (pos_y),
		.tex_u          (tex_u),
		.tex_v          (tex_v),
		.chunk_has_tile (chunk_has_tile),
		.last_of_tile   (last_of_tile),
		.last_of_chunk  (last_of_chunk),
		.last_of_map    (last_of_map)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic int unsigned clamp_dim(input int unsigned val, input int unsigned hi);
		if (val == 0)
			return 1;
		if (val > hi)
			return hi;
		return val;
	endfunction

	function automatic void restart_scan();
		scan_col   = 0;
		scan_row   = 0;
		tile_x     = 0;
		tile_y     = 0;
		chunk_seen = 1'b0;
	endfunction

	// Six vertex words of one tile, queued in order; then the scan moves on
	function automatic void build_quad(input logic [TILE_W-1:0] t);
		int unsigned cols, rows, cs, ts, tpr, raw, ccols, crows, ox, oy, w, h, mx, my, tu, tv;
		bit empty, end_chunk, end_map, right, bottom;
		longint unsigned px, py, u, v;
		vertex_t vx;
		cols  = clamp_dim(32'(shadow.cols), MAX_MAP_DIM);
		rows  = clamp_dim(32'(shadow.rows), MAX_MAP_DIM);
		cs    = clamp_dim(32'(shadow.cs), MAX_CHUNK_DIM);
		ts    = clamp_dim(32'(shadow.ts), MAX_TILE_PIX);
		tpr   = clamp_dim(32'(shadow.tpr), MAX_ATLAS_ROW);
		raw   = 32'(t);
		empty = t[TILE_W-1];
		ccols = (cols + cs - 1) / cs;
		crows = (rows + cs - 1) / cs;
		ox    = scan_col * cs;
		oy    = scan_row * cs;
		if (ox >= cols || oy >= rows) begin
			restart_scan();
			ox = 0;
			oy = 0;
		end
		// edge chunks are clipped to the map
		w = (cols - ox < cs) ? cols - ox : cs;
		h = (rows - oy < cs) ? rows - oy : cs;
		if (tile_x >= w || tile_y >= h) begin
			tile_x = 0;
			tile_y = 0;
		end
		mx = ox + tile_x;
		my = oy + tile_y;
		if (!empty)
			chunk_seen = 1'b1;
		tu = raw % tpr;
		tv = raw / tpr;
		end_chunk = (tile_x + 1 == w) && (tile_y + 1 == h);
		end_map   = end_chunk && (scan_col + 1 >= ccols) && (scan_row + 1 >= crows);

		for (int k = 0; k < 6; k++) begin
			right  = (k == 1 || k == 2 || k == 4);
			bottom = (k == 2 || k == 4 || k == 5);
			px = 0;
			py = 0;
			u  = 0;
			v  = 0;
			if (!empty) begin
				px = 64'(mx) * 64'(ts) + (right ? 64'(ts) : 64'd0);
				py = 64'(my) * 64'(ts) + (bottom ? 64'(ts) : 64'd0);
				u  = (64'(tu) * 64'(ts) + (right ? 64'(ts) : 64'd0)) * 64'd256;
				v  = (64'(tv) * 64'(ts) + (bottom ? 64'(ts) : 64'd0)) * 64'd256;
				u  = right ? u - 64'(shadow.inset) : u + 64'(shadow.inset);
				v  = bottom ? v - 64'(shadow.inset) : v + 64'(shadow.inset);
				if (px > POS_CEIL) px = POS_CEIL;
				if (py > POS_CEIL) py = POS_CEIL;
				if (u > TEX_CEIL) u = TEX_CEIL;
				if (v > TEX_CEIL) v = TEX_CEIL;
			end
			vx.ccol      = CHUNK_W'(scan_col);
			vx.crow      = CHUNK_W'(scan_row);
			vx.slot      = SLOT_W'(k);
			vx.px        = px[POS_W-1:0];
			vx.py        = py[POS_W-1:0];
			vx.u         = u[TEX_W-1:0];
			vx.v         = v[TEX_W-1:0];
			vx.has_tile  = chunk_seen;
			vx.end_tile  = (k == 5);
			vx.end_chunk = (k == 5) && end_chunk;
			vx.end_map   = (k == 5) && end_map;
			pending_vertices = {pending_vertices, vx};
		end

		if (!end_chunk) begin
			if (tile_x + 1 < w) begin
				tile_x++;
			end else begin
				tile_x = 0;
				tile_y++;
			end
		end else begin
			tile_x     = 0;
			tile_y     = 0;
			chunk_seen = 1'b0;
			if (end_map) begin
				scan_col = 0;
				scan_row = 0;
			end else if (scan_col + 1 < ccols) begin
				scan_col++;
			end else begin
				scan_col = 0;
				scan_row++;
			end
		end
	endfunction

	function automatic int unsigned pick_size();
		case ($urandom_range(0, 3))
			0:       return 1;
			1:       return 256;
			default: return $urandom_range(2, 255);
		endcase
	endfunction

	// random bits above the register's own width, half the time
	function automatic logic [CFG_W-1:0] with_junk(input int unsigned val, input int w);
		logic [CFG_W-1:0] junk;
		junk = CFG_W'($urandom);
		junk = (junk >> w) << w;
		return (($urandom_range(0, 1) == 0) ? '0 : junk) | CFG_W'(val);
	endfunction

	task automatic check_field(input string name, input logic [63:0] want, input logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	task automatic push_tile(input logic [TILE_W-1:0] t);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		in_valid   <= 1'b1;
		tile_index <= t;
		do @(posedge clk); while (in_stall);
		build_quad(t);
		tiles_sent++;
	endtask

	// only once the block has drained; a write to a used index restarts the scan
	task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
		bit known;
		in_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		@(posedge clk);
		cfg_write <= 1'b0;
		known = 1'b1;
		case (idx)
			REG_MAP_COLS:   shadow.cols  = data[COL_W-1:0];
			REG_MAP_ROWS:   shadow.rows  = data[COL_W-1:0];
			REG_CHUNK_SIZE: shadow.cs    = data[CS_W-1:0];
			REG_TILE_SIZE:  shadow.ts    = data[TS_W-1:0];
			REG_ATLAS_ROW:  shadow.tpr   = data[TPR_W-1:0];
			REG_TEX_INSET:  shadow.inset = data[INSET_W-1:0];
			default:        known = 1'b0;
		endcase
		if (known)
			restart_scan();
		reg_writes++;
	endtask

	// small clipped maps so chunk ends and map wraps come often
	task automatic run_phase(input bit gaps, input bit stalls, input bit long_hold);
		logic [TILE_W-1:0] t;
		write_reg(REG_MAP_COLS, CFG_W'($urandom_range(1, 12)));
		write_reg(REG_MAP_ROWS, CFG_W'($urandom_range(1, 9)));
		write_reg(REG_CHUNK_SIZE, with_junk($urandom_range(1, 5), CS_W));
		write_reg(REG_TILE_SIZE, with_junk(pick_size(), TS_W));
		write_reg(REG_ATLAS_ROW, with_junk(pick_size(), TPR_W));
		write_reg(REG_TEX_INSET, with_junk($urandom_range(0, 255), INSET_W));
		gaps_on   = gaps;
		stalls_on = stalls;
		if (long_hold)
			hold_req = 1'b1;
		repeat (PHASE_TILES) begin
			case ($urandom_range(0, 19))
				0, 1, 2: t = {1'b1, 12'($urandom)};
				3:       t = '0;
				4:       t = TOP_TILE;
				5:       t = EMPTY_TILE;
				default: t = TILE_W'($urandom_range(0, 4095));
			endcase
			push_tile(t);
		end
	endtask

	// output side: take and check a word, then choose the next stall
	always @(posedge clk) begin : vertex_sink
		vertex_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_vertices.size() == 0) begin
				$error("vertex word with nothing expected: slot %0d", vertex_slot);
				mismatches++;
			end else begin
				want = pending_vertices.pop_front();
				check_field("chunk_col", 64'(want.ccol), 64'(chunk_col));
				check_field("chunk_row", 64'(want.crow), 64'(chunk_row));
				check_field("vertex_slot", 64'(want.slot), 64'(vertex_slot));
				check_field("pos_x", 64'(want.px), 64'(pos_x));
				check_field("pos_y", 64'(want.py), 64'(pos_y));
				check_field("tex_u", 64'(want.u), 64'(tex_u));
				check_field("tex_v", 64'(want.v), 64'(tex_v));
				check_field("chunk_has_tile", 64'(want.has_tile), 64'(chunk_has_tile));
				check_field("last_of_tile", 64'(want.end_tile), 64'(last_of_tile));
				check_field("last_of_chunk", 64'(want.end_chunk), 64'(last_of_chunk));
				check_field("last_of_map", 64'(want.end_map), 64'(last_of_map));
				vertices_checked++;
			end
		end
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_stall <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			out_stall <= 1'b1;
		end else if (stalls_on && $urandom_range(0, 4) == 0) begin
			stall_left = $urandom_range(1, 6) - 1;
			out_stall <= 1'b1;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// timeout
	initial begin : watchdog
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("timeout after %0d cycles, %0d words outstanding", cycles,
			pending_vertices.size());
		$display("end of test: mismatches");
		$finish;
	end

	initial begin : stimulus
		int base;
		shadow.cols  = 11'd64;
		shadow.rows  = 11'd64;
		shadow.cs    = 7'd16;
		shadow.ts    = 9'd16;
		shadow.tpr   = 9'd16;
		shadow.inset = 8'd0;
		restart_scan();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i]) begin
			if (script[i].kind == ROW_REG) begin
				write_reg(script[i].idx, script[i].data);
			end else begin
				push_tile(script[i].tile);
				if (script[i].typed) begin
					base = pending_vertices.size() - 6;
					pending_vertices[base].px = script[i].x0;
					pending_vertices[base].py = script[i].y0;
					pending_vertices[base].u  = script[i].u0;
					pending_vertices[base].v  = script[i].v0;
				end
			end
		end

		run_phase(1'b1, 1'b1, 1'b0);
		run_phase(1'b1, 1'b1, 1'b1);	// long hold on the output fills the block
		run_phase(1'b1, 1'b1, 1'b0);
		run_phase(1'b1, 1'b0, 1'b0);
		run_phase(1'b0, 1'b1, 1'b0);
		run_phase(1'b0, 1'b0, 1'b0);	// back to back, no idling

		in_valid <= 1'b0;
		while (pending_vertices.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("%0d tiles, %0d vertex words checked, %0d register writes in %0d cycles",
			tiles_sent, vertices_checked, reg_writes, cycles);
		$display("covered clipped chunks, map wrap, empty tiles, clamped registers, saturation");
		if (mismatches == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

[sim.f]
hw/rtl/tcqg_pkg.sv
hw/rtl/tcqg_divider.sv
hw/rtl/tcqg_sequencer.sv
hw/rtl/tcqg_datapath.sv
hw/rtl/tile_chunk_quad_generator_unit.sv
tb/tb.sv
